/* design/cc_cv_charge_and_discharge_monitor_macros.svh */
// assertion macros for the charge and discharge monitor
`ifndef CC_CV_CHARGE_AND_DISCHARGE_MONITOR_MACROS_SVH
`define CC_CV_CHARGE_AND_DISCHARGE_MONITOR_MACROS_SVH

// same-cycle implication, checked at every rising clock edge out of reset
`define CCM_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ccm assertion failed");

// next-cycle implication, checked at every rising clock edge out of reset
`define CCM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ccm assertion failed");

`endif

/* design/ccm_pkg.sv */
// package: types, codes and the constant-current step for the charge monitor
`default_nettype none

package ccm_pkg;

   localparam logic [6:0] DUTY_MAX      = 7'd100;
   localparam logic [3:0] CHARGE_DIVIDE = 4'd10;

   // battery led codes
   localparam logic [2:0] LED_OFF     = 3'd0;
   localparam logic [2:0] LED_SHORT   = 3'd1;
   localparam logic [2:0] LED_BLINK1  = 3'd2;
   localparam logic [2:0] LED_BLINK2  = 3'd3;
   localparam logic [2:0] LED_BLINK3  = 3'd4;
   localparam logic [2:0] LED_STEADY1 = 3'd5;
   localparam logic [2:0] LED_STEADY2 = 3'd6;
   localparam logic [2:0] LED_STEADY3 = 3'd7;

   // buzzer codes
   localparam logic [2:0] BUZ_OFF       = 3'd0;
   localparam logic [2:0] BUZ_SLOW      = 3'd1;
   localparam logic [2:0] BUZ_FAST      = 3'd2;
   localparam logic [2:0] BUZ_VERY_FAST = 3'd3;
   localparam logic [2:0] BUZ_PERMANENT = 3'd4;

   // external led codes
   localparam logic [1:0] EXT_OFF   = 2'd0;
   localparam logic [1:0] EXT_ON    = 2'd1;
   localparam logic [1:0] EXT_BLINK = 2'd2;

   // host level codes
   localparam logic [1:0] HOST_HIGH     = 2'd0;
   localparam logic [1:0] HOST_MIDDLE   = 2'd1;
   localparam logic [1:0] HOST_LOW      = 2'd2;
   localparam logic [1:0] HOST_SHUTDOWN = 2'd3;

   // tick kinds
   localparam logic MODE_CHARGE  = 1'b0;
   localparam logic MODE_BATTERY = 1'b1;

   // configuration register indexes
   localparam logic [2:0] CSR_CC_CURRENT  = 3'd0;
   localparam logic [2:0] CSR_CV_VOLTAGE  = 3'd1;
   localparam logic [2:0] CSR_NO_BATTERY  = 3'd2;
   localparam logic [2:0] CSR_CHG_LEVELS  = 3'd3;
   localparam logic [2:0] CSR_DIS_LEVELS  = 3'd4;
   localparam logic [2:0] CSR_SHDN_TICKS  = 3'd5;
   localparam logic [2:0] CSR_DWELL_TICKS = 3'd6;

   localparam int CSR_DATA_W = 48;

   typedef struct packed {
      logic [11:0] cc_current_target;
      logic [11:0] cv_voltage_target;
      logic [11:0] missing_bat_level;
      logic [35:0] charge_levels;
      logic [47:0] discharge_levels;
      logic [15:0] shutdown_ticks;
      logic [7:0]  cv_dwell_ticks;
   } cfg_type;

   typedef struct packed {
      logic        mode;
      logic [11:0] battery_voltage;
      logic [11:0] charger_voltage;
      logic [11:0] charge_current;
   } req_type;

   typedef struct packed {
      logic [6:0]  duty;
      logic        cv_mode;
      logic        shutdown_armed;
      logic [3:0]  step_divider;
      logic [7:0]  dwell_count;
      logic [15:0] shutdown_count;
      logic [2:0]  led;
      logic [2:0]  buzzer;
      logic [1:0]  ext_led;
      logic [1:0]  host_level;
      logic        charger_on;
   } state_type;

   typedef struct packed {
      logic [6:0] duty;
      logic       fault;
   } cc_result_type;

   // one constant-current step; a missing battery takes one extra decrement
   function automatic cc_result_type cc_step(input logic [6:0]  duty,
                                             input logic [11:0] vbat,
                                             input logic [11:0] cur,
                                             input logic [11:0] cc_target,
                                             input logic [11:0] no_bat);
      cc_result_type r;
      r.duty  = duty;
      r.fault = 1'b0;
      if (cur < cc_target) begin
         if (r.duty < DUTY_MAX) r.duty = r.duty + 7'd1;
         else r.fault = 1'b1;
      end else begin
         if (r.duty > 7'd0) r.duty = r.duty - 7'd1;
         else r.fault = 1'b1;
      end
      if (vbat > no_bat) begin
         if (r.duty > 7'd0) r.duty = r.duty - 7'd1;
         r.fault = 1'b1;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* design/ccm_core.sv */
// next-state logic for one tick: charge regulation and battery grading
`default_nettype none

module ccm_core (
   input  ccm_pkg::state_type state,
   input  ccm_pkg::cfg_type   cfg,
   input  ccm_pkg::req_type   req,
   output ccm_pkg::state_type state_next,
   output logic               fire
);
   import ccm_pkg::*;

   logic [11:0] l1, l2, l3;
   logic [11:0] lv_hi, lv_mid, lv_lo, lv_crit;
   logic [11:0] vbat;

   assign vbat    = req.battery_voltage;
   assign l1      = cfg.charge_levels[11:0];
   assign l2      = cfg.charge_levels[23:12];
   assign l3      = cfg.charge_levels[35:24];
   assign lv_hi   = cfg.discharge_levels[11:0];
   assign lv_mid  = cfg.discharge_levels[23:12];
   assign lv_lo   = cfg.discharge_levels[35:24];
   assign lv_crit = cfg.discharge_levels[47:36];

   // bands are tested in order; misordered levels may step the duty more than once
   always_comb begin
      state_type     s;
      cc_result_type cr;
      logic          graded;
      s      = state;
      cr     = '0;
      graded = 1'b0;
      fire   = 1'b0;

      if (req.mode == MODE_CHARGE) begin
         s.step_divider = s.step_divider + 4'd1;
         if (s.step_divider >= CHARGE_DIVIDE) begin
            s.step_divider   = 4'd0;
            s.charger_on     = 1'b1;
            s.buzzer         = BUZ_OFF;
            s.ext_led        = EXT_ON;
            s.shutdown_armed = 1'b0;

            // constant current bands
            if (!s.cv_mode) begin
               if (vbat < l1) begin
                  cr = cc_step(s.duty, vbat, req.charge_current,
                               cfg.cc_current_target, cfg.missing_bat_level);
                  s.duty        = cr.duty;
                  s.led         = cr.fault ? LED_SHORT : LED_BLINK1;
                  s.dwell_count = 8'd0;
               end
               if (vbat > l1 && vbat < l2) begin
                  cr = cc_step(s.duty, vbat, req.charge_current,
                               cfg.cc_current_target, cfg.missing_bat_level);
                  s.duty        = cr.duty;
                  s.led         = LED_BLINK2;
                  s.dwell_count = 8'd0;
               end
               if (vbat > l2 && vbat < l3) begin
                  cr = cc_step(s.duty, vbat, req.charge_current,
                               cfg.cc_current_target, cfg.missing_bat_level);
                  s.duty        = cr.duty;
                  s.led         = LED_BLINK3;
                  s.dwell_count = 8'd0;
               end
               if (vbat > l3) begin
                  cr = cc_step(s.duty, vbat, req.charge_current,
                               cfg.cc_current_target, cfg.missing_bat_level);
                  s.duty = cr.duty;
                  s.led  = LED_BLINK3;
                  if (s.dwell_count < cfg.cv_dwell_ticks) begin
                     if (s.dwell_count != 8'hFF) s.dwell_count = s.dwell_count + 8'd1;
                  end else begin
                     s.dwell_count = 8'd0;
                     s.cv_mode     = 1'b1;
                  end
               end
            end

            // constant voltage, also entered on the tick that ends the dwell
            if (s.cv_mode) begin
               if (req.charger_voltage < cfg.cv_voltage_target) begin
                  if (s.duty < DUTY_MAX) s.duty = s.duty + 7'd1;
               end else begin
                  if (s.duty > 7'd0) s.duty = s.duty - 7'd1;
               end
               s.led = LED_STEADY3;
               if (vbat < l1 || req.charge_current > cfg.cc_current_target)
                  s.cv_mode = 1'b0;
               s.dwell_count = 8'd0;
            end
         end
      end else begin
         s.charger_on = 1'b0;
         s.duty       = 7'd0;
         s.cv_mode    = 1'b0;
         s.ext_led    = EXT_BLINK;

         // grading; first matching band wins; the three level bands skip the shutdown timer, the lowest band arms it
         if (!s.shutdown_armed) begin
            if (vbat > lv_hi) begin
               s.host_level = HOST_HIGH;   s.buzzer = BUZ_SLOW;
               s.led = LED_STEADY3;        s.shutdown_count = 16'd0;
               graded = 1'b1;
            end else if (vbat > lv_mid && vbat < lv_hi) begin
               s.host_level = HOST_MIDDLE; s.buzzer = BUZ_FAST;
               s.led = LED_STEADY2;        s.shutdown_count = 16'd0;
               graded = 1'b1;
            end else if (vbat > lv_lo && vbat < lv_mid) begin
               s.host_level = HOST_LOW;    s.buzzer = BUZ_VERY_FAST;
               s.led = LED_STEADY1;        s.shutdown_count = 16'd0;
               graded = 1'b1;
            end else if (vbat < lv_lo) begin
               s.shutdown_armed = 1'b1;
               s.shutdown_count = 16'd0;
            end
         end

         // armed shutdown timer
         if (!graded && s.shutdown_armed) begin
            s.host_level = HOST_SHUTDOWN;
            s.buzzer     = BUZ_VERY_FAST;
            s.led        = LED_OFF;
            if (s.shutdown_count != 16'hFFFF) s.shutdown_count = s.shutdown_count + 16'd1;
            if (s.shutdown_count > cfg.shutdown_ticks || vbat < lv_crit) begin
               s.buzzer         = BUZ_PERMANENT;
               s.shutdown_armed = 1'b0;
               s.shutdown_count = 16'd0;
               fire             = 1'b1;
            end
         end
      end

      state_next = s;
   end

endmodule

`default_nettype wire

/* design/cc_cv_charge_and_discharge_monitor.sv */
// top level: handshake stages, configuration registers and monitor state
`default_nettype none
`include "cc_cv_charge_and_discharge_monitor_macros.svh"

// CC/CV charge and discharge monitor. Each item is one 1 ms tick: charge
// ticks (mode 0) run the charger regulation on every tenth tick, battery
// ticks (mode 1) grade the battery level and run the shutdown timer. Every
// item gives exactly one result item, carrying the updated outputs and a
// one-tick shutdown_request pulse. An item is held in the input register
// and then evaluated combinationally into the result register, so one
// item is taken per cycle while the result side keeps up; the input side
// stalls only when a result waits to be taken and another item already
// sits in the input register. Configuration is written through csr_wr_en /
// csr_index / csr_wr_data and should only change while no item is in
// flight.
module cc_cv_charge_and_discharge_monitor (
   input  logic                              clock,
   input  logic                              reset,
   // input channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_mode,
   input  logic [11:0]                       req_battery_voltage,
   input  logic [11:0]                       req_charger_voltage,
   input  logic [11:0]                       req_charge_current,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [6:0]                        rsp_pwm_duty,
   output logic                              rsp_charger_on,
   output logic [2:0]                        rsp_battery_leds,
   output logic [2:0]                        rsp_buzzer_code,
   output logic [1:0]                        rsp_external_led,
   output logic [1:0]                        rsp_host_level,
   output logic                              rsp_cv_active,
   output logic                              rsp_shutdown_request,
   // configuration port
   input  logic                              csr_wr_en,
   input  logic [2:0]                        csr_index,
   input  logic [ccm_pkg::CSR_DATA_W-1:0]    csr_wr_data
);
   import ccm_pkg::*;

   cfg_type   cfg_ff;
   req_type   req_ff;
   logic      in_valid_ff, in_valid_in;
   logic      out_valid_ff, out_valid_in;
   state_type state_ff, state_in;
   state_type rsp_ff;
   logic      fire_ff, fire_in;
   logic      accept, advance;

   // handshake between input register and result register
   assign advance     = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !advance;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_stall ? out_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff.mode            <= req_mode;
         req_ff.battery_voltage <= req_battery_voltage;
         req_ff.charger_voltage <= req_charger_voltage;
         req_ff.charge_current  <= req_charge_current;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cc_current_target <= 12'd0;
         cfg_ff.cv_voltage_target <= 12'd0;
         cfg_ff.missing_bat_level <= 12'hFFF;
         cfg_ff.charge_levels     <= 36'd0;
         cfg_ff.discharge_levels  <= 48'd0;
         cfg_ff.shutdown_ticks    <= 16'd60000;
         cfg_ff.cv_dwell_ticks    <= 8'd100;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_CC_CURRENT:  cfg_ff.cc_current_target <= csr_wr_data[11:0];
            CSR_CV_VOLTAGE:  cfg_ff.cv_voltage_target <= csr_wr_data[11:0];
            CSR_NO_BATTERY:  cfg_ff.missing_bat_level <= csr_wr_data[11:0];
            CSR_CHG_LEVELS:  cfg_ff.charge_levels     <= csr_wr_data[35:0];
            CSR_DIS_LEVELS:  cfg_ff.discharge_levels  <= csr_wr_data[47:0];
            CSR_SHDN_TICKS:  cfg_ff.shutdown_ticks    <= csr_wr_data[15:0];
            CSR_DWELL_TICKS: cfg_ff.cv_dwell_ticks    <= csr_wr_data[7:0];
            default: ;
         endcase
      end
   end

   // per-tick evaluation
   ccm_core u_core (
      .state      (state_ff),
      .cfg        (cfg_ff),
      .req        (req_ff),
      .state_next (state_in),
      .fire       (fire_in)
   );

   // monitor state, updated once per evaluated item
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff  <= state_in;
         fire_ff <= fire_in;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_pwm_duty         = rsp_ff.duty;
   assign rsp_charger_on       = rsp_ff.charger_on;
   assign rsp_battery_leds     = rsp_ff.led;
   assign rsp_buzzer_code      = rsp_ff.buzzer;
   assign rsp_external_led     = rsp_ff.ext_led;
   assign rsp_host_level       = rsp_ff.host_level;
   assign rsp_cv_active        = rsp_ff.cv_mode;
   assign rsp_shutdown_request = fire_ff;

   // checks
   `CCM_ASSERT_NOW(a_fire_buzzer, rsp_valid && rsp_shutdown_request, rsp_buzzer_code == BUZ_PERMANENT)
   `CCM_ASSERT_NOW(a_duty_max, rsp_valid, rsp_pwm_duty <= DUTY_MAX)
   `CCM_ASSERT_NOW(a_off_zero_duty, rsp_valid && !rsp_charger_on, rsp_pwm_duty == 7'd0)
   `CCM_ASSERT_NOW(a_cv_needs_charger, rsp_valid && rsp_cv_active, rsp_charger_on)
   `CCM_ASSERT_NEXT(a_stall_holds_input, req_stall, in_valid_ff)

endmodule

`default_nettype wire
